/* design/ndef_enc_pkg.sv */
// Package for the NDEF record encoder: register indexes, flag bits and sizes.
package ndef_enc_pkg;

    localparam int unsigned HDR_MAX    = 7;
    localparam int unsigned CNT_W      = $clog2(HDR_MAX + 1);
    localparam int unsigned LEFT_W     = 17;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [7:0] FLAG_MB = 8'h80;
    localparam logic [7:0] FLAG_ME = 8'h40;
    localparam logic [7:0] FLAG_SR = 8'h10;
    localparam logic [7:0] FLAG_IL = 8'h08;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_CONTENT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NAME_FORMAT      = 3'd0,
        CFG_TYPE_LEN         = 3'd1,
        CFG_PAYLOAD_LEN      = 3'd2,
        CFG_IDENT_LEN        = 3'd3,
        CFG_FIRST_IN_MESSAGE = 3'd4,
        CFG_LAST_IN_MESSAGE  = 3'd5
    } t_cfg_index;

endpackage

/* design/ndef_record_encoder.sv */
// Top level of the NDEF record encoder: header framing and content pass-through.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_ready     | i_kind, i_content_byte
//  result   | o_out_valid / i_out_ready   | o_out_byte, o_run_last, o_record_end,
//           |                             | o_overflow
//  config   | i_cfg_wr_en (no wait)       | i_cfg_index, i_cfg_data
//
// A content item yields one result byte, and the block takes one content item per cycle
// while the receiver takes every result. A start item yields three to seven header bytes,
// one per cycle from the result buffer while the receiver is ready.
// A new item is taken in the cycle that the last buffered result leaves, so there is no
// bubble between items. Reset is synchronous and active low; it clears the registers,
// the record state and the buffer count. A stalled result holds until it is taken.
module ndef_record_encoder
    import ndef_enc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [7:0]            i_content_byte,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_run_last,
    output logic                  o_record_end,
    output logic                  o_overflow
);

    // Configuration registers.
    logic [2:0]  r_name_format;
    logic [7:0]  r_type_len;
    logic [15:0] r_payload_len;
    logic [7:0]  r_ident_len;
    logic        r_first_in_message;
    logic        r_last_in_message;

    // Record state.
    logic [LEFT_W-1:0] r_bytes_left, n_bytes_left;
    logic              r_in_record,  n_in_record;

    // Result buffer: entry 0 is the byte on the output. The remaining count marks the
    // last entry, which carries the end-of-record and overflow marks of the whole run.
    logic [7:0]       r_buf [HDR_MAX];
    logic [7:0]       n_buf [HDR_MAX];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_end, n_end;
    logic             r_ovf, n_ovf;

    logic              accept;
    logic              pop;
    logic              short_form;
    logic              has_ident;
    logic [7:0]        flags;
    logic [LEFT_W-1:0] total;
    logic [7:0]        hdr [HDR_MAX];
    logic [CNT_W-1:0]  hdr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_format      <= '0;
            r_type_len         <= '0;
            r_payload_len      <= '0;
            r_ident_len        <= '0;
            r_first_in_message <= 1'b0;
            r_last_in_message  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_NAME_FORMAT:      r_name_format      <= i_cfg_data[2:0];
                CFG_TYPE_LEN:         r_type_len         <= i_cfg_data[7:0];
                CFG_PAYLOAD_LEN:      r_payload_len      <= i_cfg_data;
                CFG_IDENT_LEN:        r_ident_len        <= i_cfg_data[7:0];
                CFG_FIRST_IN_MESSAGE: r_first_in_message <= i_cfg_data[0];
                CFG_LAST_IN_MESSAGE:  r_last_in_message  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The buffer is free when it is empty or its last entry leaves this cycle.
    assign pop        = (r_cnt != '0) && i_out_ready;
    assign o_in_ready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Header layout. Short form: flags, type length, payload length, then the id length
    // if there is an id. Long form puts a four-byte big-endian length in the middle,
    // whose upper two bytes are always zero.
    assign short_form = (r_payload_len[15:8] == 8'd0);
    assign has_ident  = (r_ident_len != 8'd0);
    assign total      = LEFT_W'(r_type_len) + LEFT_W'(r_payload_len) + LEFT_W'(r_ident_len);

    always_comb begin
        flags = {5'd0, r_name_format};
        if (r_first_in_message) flags = flags | FLAG_MB;
        if (r_last_in_message)  flags = flags | FLAG_ME;
        if (short_form)         flags = flags | FLAG_SR;
        if (has_ident)          flags = flags | FLAG_IL;

        hdr[0] = flags;
        hdr[1] = r_type_len;
        hdr[2] = short_form ? r_payload_len[7:0] : 8'd0;
        hdr[3] = short_form ? r_ident_len        : 8'd0;
        hdr[4] = r_payload_len[15:8];
        hdr[5] = r_payload_len[7:0];
        hdr[6] = r_ident_len;
        hdr_cnt = (short_form ? CNT_W'(3) : CNT_W'(6)) + CNT_W'(has_ident);
    end

    always_comb begin
        n_buf        = r_buf;
        n_cnt        = r_cnt;
        n_end        = r_end;
        n_ovf        = r_ovf;
        n_bytes_left = r_bytes_left;
        n_in_record  = r_in_record;

        if (pop) begin
            for (int i = 0; i < HDR_MAX - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end

        if (accept) begin
            if (i_kind == KIND_START) begin
                // A start abandons any open record and takes the lengths as they are now.
                n_buf        = hdr;
                n_cnt        = hdr_cnt;
                n_end        = (total == '0);
                n_ovf        = 1'b0;
                n_bytes_left = total;
                n_in_record  = (total != '0);
            end else if (!r_in_record || (r_bytes_left == '0)) begin
                // Unexpected content: flagged, the record state stays as it is.
                n_buf[0] = 8'd0;
                n_cnt    = CNT_W'(1);
                n_end    = 1'b0;
                n_ovf    = 1'b1;
            end else begin
                n_buf[0]     = i_content_byte;
                n_cnt        = CNT_W'(1);
                n_end        = (r_bytes_left == LEFT_W'(1));
                n_ovf        = 1'b0;
                n_bytes_left = r_bytes_left - LEFT_W'(1);
                n_in_record  = (r_bytes_left != LEFT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_end        <= 1'b0;
            r_ovf        <= 1'b0;
            r_bytes_left <= '0;
            r_in_record  <= 1'b0;
        end else begin
            r_cnt        <= n_cnt;
            r_end        <= n_end;
            r_ovf        <= n_ovf;
            r_bytes_left <= n_bytes_left;
            r_in_record  <= n_in_record;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_out_valid  = (r_cnt != '0);
    assign o_out_byte   = r_buf[0];
    assign o_run_last   = (r_cnt == CNT_W'(1));
    assign o_record_end = o_run_last && r_end;
    assign o_overflow   = o_run_last && r_ovf;

endmodule

/* design/ndef_enc_checker.sv */
// Port-level checks for the NDEF record encoder, bound to the top level.
module ndef_enc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_kind,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_record_end,
    input logic       o_overflow
);

    // A stalled result keeps its byte.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte))
        else $error("stalled result changed");

    // The end of a record closes the run of results of its item.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_end |-> o_run_last)
        else $error("record end not on last result of its item");

    // A flagged byte stands alone, is zero and never ends a record.
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_run_last && !o_record_end && o_out_byte == 8'd0)
        else $error("bad overflow result");

    // A new item is taken only when no result is pending or the last one leaves.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid || (o_run_last && i_out_ready))
        else $error("item taken while results pending");

    // A start always produces a header of several bytes.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_kind |=> o_out_valid && !o_run_last)
        else $error("header too short");

endmodule

bind ndef_record_encoder ndef_enc_checker u_ndef_enc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_kind       (i_kind),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_run_last   (o_run_last),
    .o_record_end (o_record_end),
    .o_overflow   (o_overflow)
);

/* dv/ndef_record_encoder_tb.sv */
// Self-checking testbench for the NDEF record encoder with a byte-level scoreboard.
`timescale 1ns / 100ps

import ndef_enc_pkg::*;

// One result byte as it leaves the encoder.
typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       rec_end;
    logic       ovf;
} ndef_out_t;

// Tracks the register file and the open record and keeps the bytes still owed by the block.
class ndef_byte_tracker;
    ndef_out_t   expected_bytes[$];
    logic [2:0]  tnf;
    logic [7:0]  type_len;
    logic [15:0] payload_len;
    logic [7:0]  ident_len;
    logic        first_msg;
    logic        last_msg;
    logic [16:0] content_left;
    logic        record_open;
    int          errors;
    int          results_seen;
    int          starts_seen;
    int          overflows_seen;
    int          record_ends_seen;

    function new();
        tnf              = '0;
        type_len         = '0;
        payload_len      = '0;
        ident_len        = '0;
        first_msg        = 1'b0;
        last_msg         = 1'b0;
        content_left     = '0;
        record_open      = 1'b0;
        errors           = 0;
        results_seen     = 0;
        starts_seen      = 0;
        overflows_seen   = 0;
        record_ends_seen = 0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    function void set_reg(t_cfg_index idx, logic [15:0] value);
        case (idx)
            CFG_NAME_FORMAT:      tnf         = value[2:0];
            CFG_TYPE_LEN:         type_len    = value[7:0];
            CFG_PAYLOAD_LEN:      payload_len = value;
            CFG_IDENT_LEN:        ident_len   = value[7:0];
            CFG_FIRST_IN_MESSAGE: first_msg   = value[0];
            CFG_LAST_IN_MESSAGE:  last_msg    = value[0];
            default: ;
        endcase
    endfunction

    // Works out the bytes that one accepted item must produce.
    function void take_item(logic kind, logic [7:0] value);
        logic [7:0]  hdr[$];
        logic [7:0]  flags;
        logic [16:0] total;
        ndef_out_t   res;
        if (kind == KIND_START) begin
            starts_seen++;
            flags = {5'b00000, tnf};
            if (first_msg) flags = flags | FLAG_MB;
            if (last_msg) flags = flags | FLAG_ME;
            if (payload_len <= 16'd255) flags = flags | FLAG_SR;
            if (ident_len != 8'd0) flags = flags | FLAG_IL;
            hdr.push_back(flags);
            hdr.push_back(type_len);
            if (payload_len <= 16'd255) begin
                hdr.push_back(payload_len[7:0]);
            end else begin
                hdr.push_back(8'h00);
                hdr.push_back(8'h00);
                hdr.push_back(payload_len[15:8]);
                hdr.push_back(payload_len[7:0]);
            end
            if (ident_len != 8'd0) hdr.push_back(ident_len);
            // The lengths are latched here; later register writes leave this record alone.
            total        = {9'd0, type_len} + {1'b0, payload_len} + {9'd0, ident_len};
            content_left = total;
            record_open  = (total != 17'd0);
            for (int i = 0; i < hdr.size(); i++) begin
                res.data     = hdr[i];
                res.run_last = (i == hdr.size() - 1);
                res.rec_end  = res.run_last && (total == 17'd0);
                res.ovf      = 1'b0;
                expected_bytes.push_back(res);
            end
        end else if (!record_open || content_left == 17'd0) begin
            res.data     = 8'h00;
            res.run_last = 1'b1;
            res.rec_end  = 1'b0;
            res.ovf      = 1'b1;
            expected_bytes.push_back(res);
        end else begin
            content_left = content_left - 17'd1;
            if (content_left == 17'd0) record_open = 1'b0;
            res.data     = value;
            res.run_last = 1'b1;
            res.rec_end  = (content_left == 17'd0);
            res.ovf      = 1'b0;
            expected_bytes.push_back(res);
        end
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
        end
    endfunction

    // Compares one accepted result byte with the oldest one owed.
    function void match_byte(logic [7:0] data, logic run_last, logic rec_end, logic ovf);
        ndef_out_t want;
        results_seen++;
        if (ovf === 1'b1) overflows_seen++;
        if (rec_end === 1'b1) record_ends_seen++;
        if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual byte %02h flags %b%b%b",
                     $time, data, run_last, rec_end, ovf);
            return;
        end
        want = expected_bytes.pop_front();
        field_check("out_byte", want.data, data);
        field_check("run_last", {7'd0, want.run_last}, {7'd0, run_last});
        field_check("record_end", {7'd0, want.rec_end}, {7'd0, rec_end});
        field_check("overflow", {7'd0, want.ovf}, {7'd0, ovf});
    endfunction
endclass

module ndef_record_encoder_tb;

    // Random items after the directed part and the long-record stretch.
    localparam int RAND_ITEMS = 180;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind         = KIND_START;
    logic [7:0]            i_content_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_run_last;
    logic                  o_record_end;
    logic                  o_overflow;

    ndef_byte_tracker tracker;

    // Percentages of cycles in which each side idles, and the receiver's long hold-off.
    int snd_idle_pct  = 7;
    int rcv_idle_pct  = 59;
    int stall_request = 0;
    int stall_left    = 0;
    int items_sent    = 0;

    ndef_record_encoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_content_byte (i_content_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_record_end   (o_record_end),
        .o_overflow     (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Result side: ready is redrawn every cycle unless a hold-off is running. A hold-off
    // request from the stimulus is picked up here and counted down in this process only.
    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Both handshakes are sampled at the clock edge, where every testbench-driven signal
    // still holds its pre-edge value. The input side is noted first so that a result of
    // the same edge always finds its expectation in place.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) tracker.take_item(i_kind, i_content_byte);
            if (o_out_valid && i_out_ready) begin
                tracker.match_byte(o_out_byte, o_run_last, o_record_end, o_overflow);
            end
        end
    end

    // Offers one item and returns at the edge where it is taken. An idle gap, when drawn,
    // drops valid first; otherwise valid stays high straight into the next item.
    task automatic send_item(input logic kind, input logic [7:0] value);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_content_byte <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stops offering and waits until every owed byte has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_index idx, input logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        tracker.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Writes the whole register file; only called while the encoder is idle.
    task automatic write_regs(input logic [2:0] tnf, input logic [7:0] tlen,
                              input logic [15:0] plen, input logic [7:0] ilen,
                              input logic mb, input logic me);
        put_reg(CFG_NAME_FORMAT, {13'd0, tnf});
        put_reg(CFG_TYPE_LEN, {8'd0, tlen});
        put_reg(CFG_PAYLOAD_LEN, plen);
        put_reg(CFG_IDENT_LEN, {8'd0, ilen});
        put_reg(CFG_FIRST_IN_MESSAGE, {15'd0, mb});
        put_reg(CFG_LAST_IN_MESSAGE, {15'd0, me});
        i_cfg_wr_en <= 1'b0;
    endtask

    // Run limit, far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [2:0]  r_tnf;
        logic [7:0]  r_type;
        logic [15:0] r_payload;
        logic [7:0]  r_ident;
        int          total;
        int          n_content;
        int          n_extra;
        int          shape;
        int          rand_base;
        int          rand_count;

        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A content item before any start must be flagged, and a start
        // with the reset registers gives an empty record closed on its last header byte.
        send_item(KIND_CONTENT, 8'hFF);
        send_item(KIND_START, 8'h5A);
        send_item(KIND_CONTENT, 8'h00);
        wait_drained();

        // All fields at their top in short form; the record is abandoned by a new start.
        write_regs(3'd7, 8'd255, 16'd255, 8'd255, 1'b1, 1'b1);
        send_item(KIND_START, 8'h00);
        send_item(KIND_CONTENT, 8'hFF);
        send_item(KIND_CONTENT, 8'h00);
        send_item(KIND_START, 8'hFF);
        wait_drained();

        // Smallest payload that needs the long length form.
        write_regs(3'd0, 8'd0, 16'd256, 8'd0, 1'b0, 1'b1);
        send_item(KIND_START, 8'h00);
        send_item(KIND_CONTENT, 8'h00);
        send_item(KIND_CONTENT, 8'hA5);
        wait_drained();

        // Longest header: long form plus the id length byte.
        write_regs(3'd5, 8'd0, 16'd65535, 8'd255, 1'b1, 1'b0);
        send_item(KIND_START, 8'h3C);
        send_item(KIND_CONTENT, 8'h81);
        wait_drained();

        // A complete small record followed by one byte too many.
        write_regs(3'd1, 8'd1, 16'd1, 8'd1, 1'b0, 1'b0);
        send_item(KIND_START, 8'h00);
        send_item(KIND_CONTENT, 8'h12);
        send_item(KIND_CONTENT, 8'h34);
        send_item(KIND_CONTENT, 8'h56);
        send_item(KIND_CONTENT, 8'h78);
        wait_drained();

        // Record that carries only an id.
        write_regs(3'd2, 8'd0, 16'd0, 8'd2, 1'b0, 1'b0);
        send_item(KIND_START, 8'h00);
        send_item(KIND_CONTENT, 8'hC3);
        send_item(KIND_CONTENT, 8'h3C);
        wait_drained();

        // Record of some seventy content bytes run to its end while the receiver holds
        // off for a long stretch, so the encoder fills up and has to stall its input.
        r_payload = 16'd60 + 16'($urandom_range(0, 8));
        write_regs(3'($urandom_range(0, 7)), 8'd2, r_payload, 8'd1,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        stall_request = 60;
        send_item(KIND_START, 8'($urandom_range(0, 255)));
        repeat (int'(r_payload) + 3) send_item(KIND_CONTENT, 8'($urandom_range(0, 255)));
        send_item(KIND_CONTENT, 8'($urandom_range(0, 255)));
        wait_drained();

        // Random part: mostly well-formed records with random content, some abandoned
        // and some with surplus bytes. The idle pattern changes by thirds.
        rand_base = items_sent;
        rand_count = 0;
        while (rand_count < RAND_ITEMS) begin
            if (rand_count < RAND_ITEMS / 3) begin
                snd_idle_pct = 7;
                rcv_idle_pct = 59;
            end else if (rand_count < 2 * RAND_ITEMS / 3) begin
                snd_idle_pct = 59;
                rcv_idle_pct = 7;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            wait_drained();
            r_tnf     = 3'($urandom_range(0, 7));
            r_type    = 8'($urandom_range(0, 3));
            r_payload = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 255))
                                                    : 16'($urandom_range(0, 6));
            r_ident   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
            write_regs(r_tnf, r_type, r_payload, r_ident,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            total = int'(r_type) + int'(r_payload) + int'(r_ident);
            repeat ($urandom_range(1, 3)) begin
                shape   = $urandom_range(0, 99);
                n_extra = 0;
                if (shape < 12 || total > 24) begin
                    n_content = $urandom_range(0, (total > 24) ? 24 : total);
                end else begin
                    n_content = total;
                    if (shape < 27) n_extra = $urandom_range(1, 2);
                end
                send_item(KIND_START, 8'($urandom_range(0, 255)));
                repeat (n_content + n_extra) begin
                    send_item(KIND_CONTENT, 8'($urandom_range(0, 255)));
                end
                // Now and then the sender pauses until the result side has caught up.
                if ($urandom_range(0, 7) == 0) wait_drained();
            end
            rand_count = items_sent - rand_base;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d items (%0d record starts) and %0d result bytes.",
                 items_sent, tracker.starts_seen, tracker.results_seen);
        $display("Seen %0d overflow flags, %0d record ends, short and long length forms.",
                 tracker.overflows_seen, tracker.record_ends_seen);
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/ndef_enc_pkg.sv
design/ndef_record_encoder.sv
design/ndef_enc_checker.sv
dv/ndef_record_encoder_tb.sv
